FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Types and constants of the palette fade engine.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int ENTRIES_PER_BANK_DEF = 64;

    // Entry pointer width: first entry plus span can reach 126.
    localparam int PTR_W = 7;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    localparam logic [2:0] MODE_NONE      = 3'd0;
    localparam logic [2:0] MODE_FADE_IN   = 3'd1;
    localparam logic [2:0] MODE_FADE_OUT  = 3'd2;
    localparam logic [2:0] MODE_FLASH_IN  = 3'd3;
    localparam logic [2:0] MODE_FLASH_OUT = 3'd4;

    localparam logic [1:0] CFG_FIRST_ENTRY = 2'd0;
    localparam logic [1:0] CFG_ENTRY_SPAN  = 2'd1;
    localparam logic [1:0] CFG_SECOND_BANK = 2'd2;

    localparam logic [7:0] STEP       = 8'd32;
    localparam logic [7:0] WHITE      = 8'd224;
    localparam logic [4:0] LAST_FRAME = 5'd21;
    localparam logic [5:0] FULL_SPAN  = 6'd63;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] bank;
        logic [5:0] index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [2:0] mode;
    } pfe_req_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       done_res;
    } pfe_res_t;

endpackage

FILE: rtl/core/palette_fade_engine_top.sv
// ----------------------------------------------------------------------------
// palette_fade_engine_top
// Four-bank RGB palette with fade-in, fade-out, flash-in and flash-out.
// ----------------------------------------------------------------------------
// The engine works on one request at a time and returns exactly one result
// transfer per request. A start for fade-in or flash-in first walks the entries
// in its range. A frame tick sweeps the working banks one entry per cycle, with
// both banks or bank A alone in play; a tick with no mode active skips the sweep.
// The sweep rate is set by the single read port of the working memory, which
// feeds one read-modify-write per cycle. Results sit in an output register, so
// the next request is taken while an earlier result still waits to be taken.
// There is no clearing pass: palette entries are undefined until written and
// must be written before they are read or used as fade targets.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_fade_engine_top #(
    parameter int ENTRIES_PER_BANK = pfe_pkg::ENTRIES_PER_BANK_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  pfe_pkg::pfe_req_t s_data,

    output logic              m_valid,
    input  logic              m_ready,
    output pfe_pkg::pfe_res_t m_data,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [5:0]        cfg_data
);

    // Working banks A and B share one memory, target banks A and B another,
    // so a tick reads a working entry and its target in the same cycle.
    localparam int WORDS = 2 * ENTRIES_PER_BANK;
    localparam int AW    = $clog2(WORDS);
    localparam int PW    = pfe_pkg::PTR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FILL,
        ST_SWEEP,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic               m_valid_reg;
    pfe_pkg::pfe_res_t  m_data_reg;
    pfe_pkg::pfe_res_t  res_reg;

    logic [2:0]         active_mode_reg;
    logic [4:0]         frame_count_reg;
    logic [5:0]         range_start_reg;
    logic [5:0]         range_span_reg;
    logic [5:0]         first_entry_reg;
    logic [5:0]         entry_span_reg;
    logic               second_bank_en_reg;

    logic               rd_targ_reg;
    logic               rd_ok_reg;
    logic [PW-1:0]      ptr_reg;
    logic               sweep_b_reg;
    logic               pass_b_reg;
    logic [23:0]        fill_colour_reg;
    logic               pipe_vld_reg;
    logic [AW-1:0]      pipe_addr_reg;

    logic [23:0]        work_mem [WORDS];
    logic [23:0]        targ_mem [WORDS];
    logic [23:0]        work_rdata_reg;
    logic [23:0]        targ_rdata_reg;

    logic               s_xfer;
    logic               idx_ok;
    logic [AW-1:0]      req_addr;
    logic [AW-1:0]      sweep_addr;
    logic [23:0]        req_pixel;
    logic [2:0]         start_mode;
    logic [PW-1:0]      range_sum;
    logic [PW-1:0]      range_end;
    logic               in_range;
    logic [23:0]        rd_word;
    logic [23:0]        wb_data;
    logic [4:0]         frame_inc;
    logic               res_post;

    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic               work_we;
    logic [AW-1:0]      work_waddr;
    logic [23:0]        work_wdata;
    logic               targ_we;

    // One colour step of a working entry for the given mode.
    function automatic logic [23:0] pix_step(input logic [2:0] mode,
                                             input logic [23:0] w,
                                             input logic [23:0] t);
        logic [7:0] wr;
        logic [7:0] wg;
        logic [7:0] wb;
        logic [7:0] tr;
        logic [7:0] tg;
        logic [7:0] tb;
        begin
            wr = w[23:16];
            wg = w[15:8];
            wb = w[7:0];
            tr = t[23:16];
            tg = t[15:8];
            tb = t[7:0];
            unique case (mode)
                pfe_pkg::MODE_FADE_IN: begin
                    if (w != t) begin
                        if (tb > wb)      wb = wb + pfe_pkg::STEP;
                        else if (tg > wg) wg = wg + pfe_pkg::STEP;
                        else if (tr > wr) wr = wr + pfe_pkg::STEP;
                    end
                end
                pfe_pkg::MODE_FLASH_IN: begin
                    if (w != t) begin
                        if (tb < wb)      wb = wb - pfe_pkg::STEP;
                        else if (tg < wg) wg = wg - pfe_pkg::STEP;
                        else if (tr < wr) wr = wr - pfe_pkg::STEP;
                    end
                end
                pfe_pkg::MODE_FADE_OUT: begin
                    if (wr != 8'd0)      wr = wr - pfe_pkg::STEP;
                    else if (wg != 8'd0) wg = wg - pfe_pkg::STEP;
                    else if (wb != 8'd0) wb = wb - pfe_pkg::STEP;
                end
                pfe_pkg::MODE_FLASH_OUT: begin
                    if (wr != pfe_pkg::WHITE)      wr = wr + pfe_pkg::STEP;
                    else if (wg != pfe_pkg::WHITE) wg = wg + pfe_pkg::STEP;
                    else if (wb != pfe_pkg::WHITE) wb = wb + pfe_pkg::STEP;
                end
                default: begin
                end
            endcase
            return {wr, wg, wb};
        end
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        s_xfer     = s_valid && s_ready;
        idx_ok     = (32'(s_data.index) < ENTRIES_PER_BANK);
        req_addr   = AW'(s_data.bank[1] ? ENTRIES_PER_BANK : 0) + AW'(s_data.index);
        sweep_addr = AW'(sweep_b_reg ? ENTRIES_PER_BANK : 0) + AW'(ptr_reg);
        req_pixel  = {s_data.red_in, s_data.green_in, s_data.blue_in};
        start_mode = (s_data.mode > pfe_pkg::MODE_FLASH_OUT) ? pfe_pkg::MODE_NONE
                                                             : s_data.mode;

        // The range ends at the last entry of a bank at the latest.
        range_sum = PW'(range_start_reg) + PW'(range_span_reg);
        range_end = (32'(range_sum) > ENTRIES_PER_BANK - 1) ? PW'(ENTRIES_PER_BANK - 1)
                                                             : range_sum;
        in_range  = (ptr_reg <= range_end);

        rd_word   = rd_targ_reg ? targ_rdata_reg : work_rdata_reg;
        wb_data   = pix_step(active_mode_reg, work_rdata_reg, targ_rdata_reg);
        frame_inc = frame_count_reg + 5'd1;

        // The pending result moves to the output register once it is free.
        res_post  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

        mem_re     = 1'b0;
        mem_raddr  = req_addr;
        work_we    = 1'b0;
        work_waddr = req_addr;
        work_wdata = req_pixel;
        targ_we    = 1'b0;

        if (s_xfer && idx_ok && (s_data.req_type == pfe_pkg::REQ_WRITE)) begin
            work_we = !s_data.bank[0];
            targ_we = s_data.bank[0];
        end
        if (s_xfer && idx_ok && (s_data.req_type == pfe_pkg::REQ_READ)) begin
            mem_re = 1'b1;
        end
        if ((state_reg == ST_FILL) && in_range) begin
            work_we    = 1'b1;
            work_waddr = AW'(ptr_reg);
            work_wdata = fill_colour_reg;
        end
        if ((state_reg == ST_SWEEP) && in_range) begin
            mem_re    = 1'b1;
            mem_raddr = sweep_addr;
        end
        // Write-back of the entry read in the previous cycle. The sweep never
        // reads an entry twice in one tick, so no forwarding is needed.
        if (pipe_vld_reg) begin
            work_we    = 1'b1;
            work_waddr = pipe_addr_reg;
            work_wdata = wb_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (work_we) begin
            work_mem[work_waddr] <= work_wdata;
        end
        if (targ_we) begin
            targ_mem[req_addr] <= req_pixel;
        end
        if (mem_re) begin
            work_rdata_reg <= work_mem[mem_raddr];
            targ_rdata_reg <= targ_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            m_valid_reg        <= 1'b0;
            active_mode_reg    <= pfe_pkg::MODE_NONE;
            frame_count_reg    <= 5'd0;
            range_start_reg    <= 6'd0;
            range_span_reg     <= pfe_pkg::FULL_SPAN;
            first_entry_reg    <= 6'd0;
            entry_span_reg     <= pfe_pkg::FULL_SPAN;
            second_bank_en_reg <= 1'b1;
            pipe_vld_reg       <= 1'b0;
        end else begin
            if (res_post) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                case (cfg_index)
                    pfe_pkg::CFG_FIRST_ENTRY: first_entry_reg    <= cfg_data;
                    pfe_pkg::CFG_ENTRY_SPAN:  entry_span_reg     <= cfg_data;
                    pfe_pkg::CFG_SECOND_BANK: second_bank_en_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end

            // Each sweep read is written back in the following cycle.
            pipe_vld_reg <= (state_reg == ST_SWEEP) && in_range;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        unique case (s_data.req_type)
                            pfe_pkg::REQ_WRITE: begin
                                res_reg   <= '0;
                                state_reg <= ST_DONE;
                            end
                            pfe_pkg::REQ_READ: begin
                                res_reg     <= '0;
                                rd_targ_reg <= s_data.bank[0];
                                rd_ok_reg   <= idx_ok;
                                state_reg   <= ST_READ;
                            end
                            pfe_pkg::REQ_START: begin
                                res_reg         <= '0;
                                active_mode_reg <= start_mode;
                                frame_count_reg <= 5'd0;
                                if (start_mode == pfe_pkg::MODE_FADE_IN) begin
                                    range_start_reg <= first_entry_reg;
                                    range_span_reg  <= entry_span_reg;
                                    ptr_reg         <= PW'(first_entry_reg);
                                    fill_colour_reg <= 24'd0;
                                    state_reg       <= ST_FILL;
                                end else if (start_mode != pfe_pkg::MODE_NONE) begin
                                    range_start_reg <= 6'd0;
                                    range_span_reg  <= pfe_pkg::FULL_SPAN;
                                    ptr_reg         <= '0;
                                    fill_colour_reg <= {3{pfe_pkg::WHITE}};
                                    state_reg <= (start_mode == pfe_pkg::MODE_FLASH_IN)
                                                 ? ST_FILL : ST_DONE;
                                end else begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            pfe_pkg::REQ_TICK: begin
                                if (active_mode_reg == pfe_pkg::MODE_NONE) begin
                                    res_reg   <= '{red_out: 8'd0, green_out: 8'd0,
                                                   blue_out: 8'd0, done_res: 1'b1};
                                    state_reg <= ST_DONE;
                                end else begin
                                    res_reg     <= '0;
                                    ptr_reg     <= PW'(range_start_reg);
                                    sweep_b_reg <= 1'b0;
                                    pass_b_reg  <= second_bank_en_reg ||
                                        (active_mode_reg == pfe_pkg::MODE_FADE_OUT) ||
                                        (active_mode_reg == pfe_pkg::MODE_FLASH_OUT);
                                    state_reg   <= ST_SWEEP;
                                end
                            end
                            default: begin
                                res_reg   <= '0;
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    if (rd_ok_reg) begin
                        res_reg.red_out   <= rd_word[23:16];
                        res_reg.green_out <= rd_word[15:8];
                        res_reg.blue_out  <= rd_word[7:0];
                    end
                    state_reg <= ST_DONE;
                end
                ST_FILL: begin
                    if (in_range) begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SWEEP: begin
                    if (in_range) begin
                        pipe_addr_reg <= sweep_addr;
                        ptr_reg       <= ptr_reg + 1'b1;
                    end else if (!sweep_b_reg && pass_b_reg) begin
                        sweep_b_reg <= 1'b1;
                        ptr_reg     <= PW'(range_start_reg);
                    end else if (!pipe_vld_reg) begin
                        // Last write-back has landed; count the frame.
                        if (frame_inc > pfe_pkg::LAST_FRAME) begin
                            frame_count_reg  <= 5'd0;
                            res_reg.done_res <= 1'b1;
                        end else begin
                            frame_count_reg <= frame_inc;
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (res_post) begin
                        m_data_reg <= res_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Write-backs only happen while a tick sweeps the working banks.
    `ASSERT_IMPLIES(a_wb_in_sweep, aclk, aresetn, pipe_vld_reg, state_reg == ST_SWEEP, "write-back outside sweep")
    // A sweep only runs with a mode active.
    `ASSERT_IMPLIES(a_sweep_mode, aclk, aresetn, state_reg == ST_SWEEP, active_mode_reg != pfe_pkg::MODE_NONE, "sweep without active mode")
    // The frame counter wraps at the last frame.
    `ASSERT_IMPLIES(a_frame_range, aclk, aresetn, 1'b1, frame_count_reg <= pfe_pkg::LAST_FRAME, "frame count past last frame")
    // A start fill touches working bank A only.
    `ASSERT_IMPLIES(a_fill_bank_a, aclk, aresetn, (state_reg == ST_FILL) && work_we, 32'(work_waddr) < ENTRIES_PER_BANK, "fill outside bank A")
    // A result is always followed by a free input side.
    `ASSERT_NEXT(a_done_to_idle, aclk, aresetn, (state_reg == ST_DONE) && (!m_valid_reg || m_ready), (state_reg == ST_IDLE) && m_valid_reg, "result not posted")

endmodule
